FILE: src/tms_pkg.sv
// ============================================================================
// tms_pkg
// Shared types, widths and constants for the triangle metrics pipeline.
// ============================================================================
package tms_pkg;

    localparam int SIDE_W   = 16;
    localparam int PERIM_W  = 18;
    localparam int AREA_W   = 24;
    localparam int ANGLE_W  = 16;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INEQ = 2'd2;

    // Front end widths.
    localparam int FACT_W = 17;
    localparam int SQ_W   = 32;
    localparam int X_W    = PERIM_W + FACT_W;
    localparam int Y_W    = 2 * FACT_W;
    localparam int HALF_W = FACT_W;
    localparam int PP_W   = X_W + HALF_W;
    localparam int PR_W   = X_W + Y_W;
    localparam int D_W    = SQ_W + 2;

    // Square root: one result bit per stage.
    localparam int SQRT_SHIFT = 56;
    localparam int SQRT_STEPS = 63;
    localparam int RAD_W      = 2 * SQRT_STEPS;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int REM_W      = ROOT_W + 3;
    localparam int AREA_LSB   = 38;

    // Angle units.
    localparam int CORDIC_STEPS = 24;
    localparam int CV_W         = 44;
    localparam int Z_W          = 28;
    localparam int POS_W        = 6;
    localparam int NORM_MSB     = 40;
    localparam int DMAG_SHIFT   = 28;
    localparam int ROUND_SHIFT  = 12;
    localparam logic [Z_W-1:0]     DEG90     = 28'd94371840;
    localparam logic [Z_W-1:0]     DEG180    = 28'd188743680;
    localparam logic [Z_W:0]       ROUND_ADD = 29'd2048;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 16'd46080;
    localparam int ANG_LAT = 3 + CORDIC_STEPS + 1;

    // atan(2^-i) in units of 2^-20 degree.
    function automatic logic [Z_W-1:0] atan_step(input logic [4:0] idx);
        logic [Z_W-1:0] v;
        case (idx)
            5'd0:  v = 28'd47185920;
            5'd1:  v = 28'd27855475;
            5'd2:  v = 28'd14718068;
            5'd3:  v = 28'd7471121;
            5'd4:  v = 28'd3750058;
            5'd5:  v = 28'd1876857;
            5'd6:  v = 28'd938658;
            5'd7:  v = 28'd469357;
            5'd8:  v = 28'd234682;
            5'd9:  v = 28'd117342;
            5'd10: v = 28'd58671;
            5'd11: v = 28'd29335;
            5'd12: v = 28'd14668;
            5'd13: v = 28'd7334;
            5'd14: v = 28'd3667;
            5'd15: v = 28'd1833;
            5'd16: v = 28'd917;
            5'd17: v = 28'd458;
            5'd18: v = 28'd229;
            5'd19: v = 28'd115;
            5'd20: v = 28'd57;
            5'd21: v = 28'd29;
            5'd22: v = 28'd14;
            5'd23: v = 28'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic [SIDE_W-1:0] side_a;
        logic [SIDE_W-1:0] side_b;
        logic [SIDE_W-1:0] side_c;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PERIM_W-1:0]  perimeter;
        logic [AREA_W-1:0]   area;
        logic [ANGLE_W-1:0]  angle_at_a;
        logic [ANGLE_W-1:0]  angle_at_b;
        logic [ANGLE_W-1:0]  angle_at_c;
        logic                is_right;
    } out_t;

    // Sideband that travels with the radicand through the square root.
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [PERIM_W-1:0]    perimeter;
        logic                  is_right;
        logic signed [D_W-1:0] d_a;
        logic signed [D_W-1:0] d_b;
        logic signed [D_W-1:0] d_c;
    } side_t;

    // Fields that wait alongside the angle units.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PERIM_W-1:0]  perimeter;
        logic                is_right;
        logic [AREA_W-1:0]   area;
    } tail_t;

endpackage

FILE: src/tms_front.sv
// ============================================================================
// tms_front
// Side checks, squares, law of cosines numerators and the Heron product.
// ============================================================================
module tms_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  tms_pkg::in_t              in_data,
    output logic                      out_valid,
    output logic [tms_pkg::PR_W-1:0]  pr,
    output tms_pkg::side_t            side
);

    localparam int FW = tms_pkg::FACT_W;
    localparam int PW = tms_pkg::PERIM_W;
    localparam int SW = tms_pkg::SQ_W;
    localparam int DW = tms_pkg::D_W;

    // Stage 1
    logic                          v1_reg;
    logic [tms_pkg::STATUS_W-1:0]  st1_reg, st1_next;
    logic [PW-1:0]                 p1_reg, p1_next;
    logic [FW-1:0]                 fa1_reg, fb1_reg, fc1_reg;
    logic [FW-1:0]                 fa1_next, fb1_next, fc1_next;
    logic [SW-1:0]                 aa1_reg, bb1_reg, cc1_reg;
    logic [FW-1:0]                 sbc, sac, sab;

    always_comb begin
        sbc      = FW'(in_data.side_b) + FW'(in_data.side_c);
        sac      = FW'(in_data.side_a) + FW'(in_data.side_c);
        sab      = FW'(in_data.side_a) + FW'(in_data.side_b);
        p1_next  = PW'(sbc) + PW'(in_data.side_a);
        fa1_next = sbc - FW'(in_data.side_a);
        fb1_next = sac - FW'(in_data.side_b);
        fc1_next = sab - FW'(in_data.side_c);
        if (in_data.side_a == '0 || in_data.side_b == '0 || in_data.side_c == '0) begin
            st1_next = tms_pkg::STATUS_ZERO;
        end else if (FW'(in_data.side_a) > sbc || FW'(in_data.side_b) > sac ||
                     FW'(in_data.side_c) > sab) begin
            st1_next = tms_pkg::STATUS_INEQ;
        end else begin
            st1_next = tms_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            st1_reg <= st1_next;
            p1_reg  <= p1_next;
            fa1_reg <= fa1_next;
            fb1_reg <= fb1_next;
            fc1_reg <= fc1_next;
            aa1_reg <= in_data.side_a * in_data.side_a;
            bb1_reg <= in_data.side_b * in_data.side_b;
            cc1_reg <= in_data.side_c * in_data.side_c;
        end
    end

    // Stage 2
    logic                          v2_reg;
    logic [tms_pkg::X_W-1:0]       x2_reg;
    logic [tms_pkg::Y_W-1:0]       y2_reg;
    tms_pkg::side_t                side2_reg, side2_next;
    logic [SW:0]                   s_bc, s_ac, s_ab;

    always_comb begin
        s_bc = (SW+1)'(bb1_reg) + (SW+1)'(cc1_reg);
        s_ac = (SW+1)'(aa1_reg) + (SW+1)'(cc1_reg);
        s_ab = (SW+1)'(aa1_reg) + (SW+1)'(bb1_reg);
        side2_next.status    = st1_reg;
        side2_next.perimeter = p1_reg;
        side2_next.is_right  = ((SW+1)'(aa1_reg) == s_bc) || ((SW+1)'(bb1_reg) == s_ac) ||
                               ((SW+1)'(cc1_reg) == s_ab);
        side2_next.d_a = $signed(DW'(s_bc)) - $signed(DW'(aa1_reg));
        side2_next.d_b = $signed(DW'(s_ac)) - $signed(DW'(bb1_reg));
        side2_next.d_c = $signed(DW'(s_ab)) - $signed(DW'(cc1_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            x2_reg    <= p1_reg * fa1_reg;
            y2_reg    <= fb1_reg * fc1_reg;
            side2_reg <= side2_next;
        end
    end

    // Stage 3: the wide product is split into two partial products.
    logic                          v3_reg;
    logic [tms_pkg::PP_W-1:0]      pl3_reg, ph3_reg;
    tms_pkg::side_t                side3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            pl3_reg   <= x2_reg * y2_reg[tms_pkg::HALF_W-1:0];
            ph3_reg   <= x2_reg * y2_reg[tms_pkg::Y_W-1:tms_pkg::HALF_W];
            side3_reg <= side2_reg;
        end
    end

    // Stage 4
    logic                          v4_reg;
    logic [tms_pkg::PR_W-1:0]      pr4_reg;
    tms_pkg::side_t                side4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
        if (en) begin
            pr4_reg   <= tms_pkg::PR_W'(pl3_reg) + {ph3_reg, {tms_pkg::HALF_W{1'b0}}};
            side4_reg <= side3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign pr        = pr4_reg;
    assign side      = side4_reg;

endmodule

FILE: src/tms_sqrt.sv
// ============================================================================
// tms_sqrt
// Pipelined restoring square root, one root bit per stage.
// ============================================================================
module tms_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [tms_pkg::PR_W-1:0]    pr,
    input  tms_pkg::side_t              in_side,
    output logic                        out_valid,
    output logic [tms_pkg::ROOT_W-1:0]  root,
    output tms_pkg::side_t              out_side
);

    localparam int N   = tms_pkg::SQRT_STEPS;
    localparam int RW  = tms_pkg::REM_W;
    localparam int QW  = tms_pkg::ROOT_W;
    localparam int DW  = tms_pkg::RAD_W;
    localparam int PAD = DW - tms_pkg::PR_W - tms_pkg::SQRT_SHIFT;

    logic                 v_reg    [N];
    logic [RW-1:0]        rem_reg  [N];
    logic [QW-1:0]        root_reg [N];
    logic [DW-1:0]        rad_reg  [N];
    tms_pkg::side_t       side_reg [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic           v_in;
        logic [RW-1:0]  rem_in, rem_sh, trial, rem_next;
        logic [QW-1:0]  root_in, root_next;
        logic [DW-1:0]  rad_in, rad_next;
        tms_pkg::side_t side_in;
        logic           take;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = {{PAD{1'b0}}, pr, {tms_pkg::SQRT_SHIFT{1'b0}}};
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb begin
            rem_sh    = {rem_in[RW-3:0], rad_in[DW-1 -: 2]};
            trial     = {1'b0, root_in, 2'b01};
            take      = rem_sh >= trial;
            rem_next  = take ? (rem_sh - trial) : rem_sh;
            root_next = {root_in[QW-2:0], take};
            rad_next  = {rad_in[DW-3:0], 2'b00};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= rad_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign root      = root_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

FILE: src/tms_angle.sv
// ============================================================================
// tms_angle
// One corner angle: normalize the operands, run a pipelined vectoring
// CORDIC, then fold and round the accumulated angle to Q8.8 degrees.
// ============================================================================
module tms_angle (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [tms_pkg::ROOT_W-1:0]        ry,
    input  logic signed [tms_pkg::D_W-1:0]    d,
    output logic                              out_valid,
    output logic [tms_pkg::ANGLE_W-1:0]       angle
);

    localparam int VW = tms_pkg::ROOT_W;
    localparam int CW = tms_pkg::CV_W;
    localparam int ZW = tms_pkg::Z_W;
    localparam int NS = tms_pkg::CORDIC_STEPS;
    localparam int PW = tms_pkg::POS_W;

    // Stage 1: magnitudes and the larger operand.
    logic            v1_reg, neg1_reg;
    logic [VW-1:0]   ux1_reg, uy1_reg, mx1_reg;
    logic [VW-1:0]   ux_next;
    logic [tms_pkg::D_W-1:0] dmag;

    always_comb begin
        dmag    = d[tms_pkg::D_W-1] ? tms_pkg::D_W'(-d) : tms_pkg::D_W'(d);
        ux_next = VW'(dmag) << tms_pkg::DMAG_SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            neg1_reg <= d[tms_pkg::D_W-1];
            ux1_reg  <= ux_next;
            uy1_reg  <= ry;
            mx1_reg  <= (ux_next > ry) ? ux_next : ry;
        end
    end

    // Stage 2: position of the leading one.
    logic            v2_reg, neg2_reg, zero2_reg;
    logic [VW-1:0]   ux2_reg, uy2_reg;
    logic [PW-1:0]   pos2_reg, pos_next;

    always_comb begin
        pos_next = '0;
        for (int i = 0; i < VW; i++) begin
            if (mx1_reg[i]) begin
                pos_next = PW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            neg2_reg  <= neg1_reg;
            zero2_reg <= (mx1_reg == '0);
            ux2_reg   <= ux1_reg;
            uy2_reg   <= uy1_reg;
            pos2_reg  <= pos_next;
        end
    end

    // Stage 3: shift both operands so the larger lands in [2^40, 2^41).
    logic            v3_reg, neg3_reg, zero3_reg;
    logic [CW-1:0]   x3_reg, y3_reg;
    logic [VW-1:0]   sx, sy;

    always_comb begin
        if (pos2_reg > PW'(tms_pkg::NORM_MSB)) begin
            sx = ux2_reg >> (pos2_reg - PW'(tms_pkg::NORM_MSB));
            sy = uy2_reg >> (pos2_reg - PW'(tms_pkg::NORM_MSB));
        end else begin
            sx = ux2_reg << (PW'(tms_pkg::NORM_MSB) - pos2_reg);
            sy = uy2_reg << (PW'(tms_pkg::NORM_MSB) - pos2_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            neg3_reg  <= neg2_reg;
            zero3_reg <= zero2_reg;
            x3_reg    <= sx[CW-1:0];
            y3_reg    <= sy[CW-1:0];
        end
    end

    // CORDIC stages.
    logic                  cv_reg   [NS];
    logic                  cneg_reg [NS];
    logic                  czero_reg[NS];
    logic signed [CW-1:0]  cx_reg   [NS];
    logic signed [CW-1:0]  cy_reg   [NS];
    logic signed [ZW-1:0]  cz_reg   [NS];

    for (genvar i = 0; i < NS; i++) begin : g_cordic
        logic                 v_in, neg_in, zero_in;
        logic signed [CW-1:0] x_in, y_in, xs, ys, x_next, y_next;
        logic signed [ZW-1:0] z_in, z_next, step;

        if (i == 0) begin : g_first
            assign v_in    = v3_reg;
            assign neg_in  = neg3_reg;
            assign zero_in = zero3_reg;
            assign x_in    = $signed(x3_reg);
            assign y_in    = $signed(y3_reg);
            assign z_in    = '0;
        end else begin : g_rest
            assign v_in    = cv_reg[i-1];
            assign neg_in  = cneg_reg[i-1];
            assign zero_in = czero_reg[i-1];
            assign x_in    = cx_reg[i-1];
            assign y_in    = cy_reg[i-1];
            assign z_in    = cz_reg[i-1];
        end

        always_comb begin
            step = $signed(tms_pkg::atan_step(5'(i)));
            xs   = x_in >>> i;
            // Shifts of a negative value round toward zero.
            ys   = y_in[CW-1] ? -((-y_in) >>> i) : (y_in >>> i);
            if (y_in > 0) begin
                x_next = x_in + ys;
                y_next = y_in - xs;
                z_next = z_in + step;
            end else begin
                x_next = x_in - ys;
                y_next = y_in + xs;
                z_next = z_in - step;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_reg[i] <= 1'b0;
            end else if (en) begin
                cv_reg[i] <= v_in;
            end
            if (en) begin
                cneg_reg[i]  <= neg_in;
                czero_reg[i] <= zero_in;
                cx_reg[i]    <= x_next;
                cy_reg[i]    <= y_next;
                cz_reg[i]    <= z_next;
            end
        end
    end

    // Final stage: clamp, fold for an obtuse angle, round half up.
    logic                        vf_reg;
    logic [tms_pkg::ANGLE_W-1:0] angf_reg, ang_next;
    logic [ZW-1:0]               zu;
    logic [ZW:0]                 zr;

    always_comb begin
        zu = cz_reg[NS-1][ZW-1] ? '0 : ZW'(cz_reg[NS-1]);
        if (zu > tms_pkg::DEG90) begin
            zu = tms_pkg::DEG90;
        end
        if (cneg_reg[NS-1]) begin
            zu = tms_pkg::DEG180 - zu;
        end
        zr = ((ZW+1)'(zu) + tms_pkg::ROUND_ADD) >> tms_pkg::ROUND_SHIFT;
        if (czero_reg[NS-1]) begin
            ang_next = '0;
        end else if (zr > (ZW+1)'(tms_pkg::ANGLE_MAX)) begin
            ang_next = tms_pkg::ANGLE_MAX;
        end else begin
            ang_next = zr[tms_pkg::ANGLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf_reg <= 1'b0;
        end else if (en) begin
            vf_reg <= cv_reg[NS-1];
        end
        if (en) begin
            angf_reg <= ang_next;
        end
    end

    assign out_valid = vf_reg;
    assign angle     = angf_reg;

endmodule

FILE: src/triangle_metrics_from_sides_top.sv
// ============================================================================
// triangle_metrics_from_sides_top
// Perimeter, Heron area, corner angles and right-angle flag from three sides.
// ============================================================================
//
//  Channel | Ports                      | Payload
//  --------+----------------------------+---------------------------------
//  input   | s_valid, s_ready, s_data   | side_a, side_b, side_c (Q8.8)
//  result  | m_valid, m_ready, m_data   | status, perimeter, area, angles,
//          |                            | is_right
//
//  One request enters per cycle while the pipeline advances; each result
//  passes 4 front stages, 63 square root stages, 28 angle stages and one
//  output register. The depth is set by the one-bit-per-stage square root.
//  Reset clears only the valid bits of every stage.
//  The whole pipeline advances together whenever the output register is
//  empty or being taken, so s_ready follows m_ready with no extra delay.
//
module triangle_metrics_from_sides_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tms_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output tms_pkg::out_t  m_data
);

    localparam int LAT = tms_pkg::ANG_LAT;

    logic en;
    logic m_valid_reg;
    tms_pkg::out_t m_data_reg, m_data_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    logic                         fr_valid;
    logic [tms_pkg::PR_W-1:0]     fr_pr;
    tms_pkg::side_t               fr_side;

    tms_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (fr_valid),
        .pr        (fr_pr),
        .side      (fr_side)
    );

    logic                         sq_valid;
    logic [tms_pkg::ROOT_W-1:0]   sq_root;
    tms_pkg::side_t               sq_side;

    tms_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .pr        (fr_pr),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    logic                         va, vb, vc;
    logic [tms_pkg::ANGLE_W-1:0]  ang_a, ang_b, ang_c;

    tms_angle u_angle_a (
        .aclk (aclk), .aresetn (aresetn), .en (en), .in_valid (sq_valid),
        .ry (sq_root), .d (sq_side.d_a), .out_valid (va), .angle (ang_a)
    );

    tms_angle u_angle_b (
        .aclk (aclk), .aresetn (aresetn), .en (en), .in_valid (sq_valid),
        .ry (sq_root), .d (sq_side.d_b), .out_valid (vb), .angle (ang_b)
    );

    tms_angle u_angle_c (
        .aclk (aclk), .aresetn (aresetn), .en (en), .in_valid (sq_valid),
        .ry (sq_root), .d (sq_side.d_c), .out_valid (vc), .angle (ang_c)
    );

    // Fields that do not pass through the angle units wait here.
    tms_pkg::tail_t tail_reg [LAT];
    tms_pkg::tail_t tail_next;

    always_comb begin
        tail_next.status    = sq_side.status;
        tail_next.perimeter = sq_side.perimeter;
        tail_next.is_right  = sq_side.is_right;
        tail_next.area      = sq_root[tms_pkg::AREA_LSB +: tms_pkg::AREA_W];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tail_reg[0] <= tail_next;
            for (int i = 1; i < LAT; i++) begin
                tail_reg[i] <= tail_reg[i-1];
            end
        end
    end

    always_comb begin
        m_data_next = '0;
        m_data_next.status = tail_reg[LAT-1].status;
        if (tail_reg[LAT-1].status == tms_pkg::STATUS_OK) begin
            m_data_next.perimeter  = tail_reg[LAT-1].perimeter;
            m_data_next.area       = tail_reg[LAT-1].area;
            m_data_next.angle_at_a = ang_a;
            m_data_next.angle_at_b = ang_b;
            m_data_next.angle_at_c = ang_c;
            m_data_next.is_right   = tail_reg[LAT-1].is_right;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= va && vb && vc;
        end
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: src/tms_checker.sv
// ============================================================================
// tms_checker
// Port-level checks for the triangle metrics block, bound to the top level.
// ============================================================================
module tms_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input tms_pkg::in_t   s_data,
    input logic           m_valid,
    input logic           m_ready,
    input tms_pkg::out_t  m_data
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A waiting request holds.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("request changed while stalled");

    // The pipeline takes a request whenever the output is free.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled with a free output");

    // Errors carry zeroed results.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != tms_pkg::STATUS_OK |->
            m_data.perimeter == '0 && m_data.area == '0 && m_data.angle_at_a == '0 &&
            m_data.angle_at_b == '0 && m_data.angle_at_c == '0 && !m_data.is_right)
        else $error("error result with nonzero fields");

    // Status codes and angles stay in range.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == tms_pkg::STATUS_OK ||
                     m_data.status == tms_pkg::STATUS_ZERO ||
                     m_data.status == tms_pkg::STATUS_INEQ) &&
                    m_data.angle_at_a <= tms_pkg::ANGLE_MAX &&
                    m_data.angle_at_b <= tms_pkg::ANGLE_MAX &&
                    m_data.angle_at_c <= tms_pkg::ANGLE_MAX)
        else $error("result out of range");

endmodule

bind triangle_metrics_from_sides_top tms_checker u_tms_checker (.*);

FILE: tb/triangle_metrics_from_sides_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// triangle_metrics_from_sides_top_tb
// Self-checking bench for the triangle metrics pipeline: directed corner
// triangles from a table, then random triangles, with random idling on both
// channels and a long result-side hold-off that fills the pipeline.
// ============================================================================
module triangle_metrics_from_sides_top_tb;

    localparam int N_RANDOM   = 1100;
    localparam int LATENCY    = 96;
    localparam int CYCLE_CAP  = 400000;
    localparam int LONG_HOLD  = 300;

    typedef struct packed {
        logic [tms_pkg::SIDE_W-1:0] a;
        logic [tms_pkg::SIDE_W-1:0] b;
        logic [tms_pkg::SIDE_W-1:0] c;
        logic                       has_fixed;
        tms_pkg::out_t              fixed;
    } dir_row_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    tms_pkg::in_t   s_data = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    tms_pkg::out_t  m_data;

    tms_pkg::out_t  expected_results[$];
    int    fail_count = 0;
    int    cycle_count = 0;
    bit    sending_done = 1'b0;
    bit    calm_phase = 1'b0;
    bit    hold_request = 1'b0;

    dir_row_t directed [] = '{
        '{16'd0,     16'd0,     16'd0,     1'b1,
          tms_pkg::out_t'{tms_pkg::STATUS_ZERO, '0, '0, '0, '0, '0, '0}},
        '{16'd0,     16'd1,     16'd1,     1'b1,
          tms_pkg::out_t'{tms_pkg::STATUS_ZERO, '0, '0, '0, '0, '0, '0}},
        '{16'd65535, 16'd0,     16'd65535, 1'b1,
          tms_pkg::out_t'{tms_pkg::STATUS_ZERO, '0, '0, '0, '0, '0, '0}},
        '{16'd9,     16'd7,     16'd0,     1'b1,
          tms_pkg::out_t'{tms_pkg::STATUS_ZERO, '0, '0, '0, '0, '0, '0}},
        '{16'd65535, 16'd1,     16'd1,     1'b1,
          tms_pkg::out_t'{tms_pkg::STATUS_INEQ, '0, '0, '0, '0, '0, '0}},
        '{16'd1,     16'd65535, 16'd2,     1'b1,
          tms_pkg::out_t'{tms_pkg::STATUS_INEQ, '0, '0, '0, '0, '0, '0}},
        '{16'd3,     16'd4,     16'd8,     1'b1,
          tms_pkg::out_t'{tms_pkg::STATUS_INEQ, '0, '0, '0, '0, '0, '0}},
        // Degenerate: the long side equals the sum of the other two.
        '{16'd2,     16'd1,     16'd1,     1'b1,
          tms_pkg::out_t'{tms_pkg::STATUS_OK, 18'd4, 24'd0, 16'd46080, 16'd0, 16'd0, 1'b0}},
        '{16'd100,   16'd65535, 16'd65435, 1'b0, '0},
        '{16'd1,     16'd1,     16'd1,     1'b0, '0},
        '{16'd65535, 16'd65535, 16'd65535, 1'b0, '0},
        '{16'd768,   16'd1024,  16'd1280,  1'b0, '0},
        '{16'd39321, 16'd52428, 16'd65535, 1'b0, '0},
        '{16'd65535, 16'd65535, 16'd1,     1'b0, '0},
        '{16'd1,     16'd32768, 16'd32768, 1'b0, '0},
        '{16'd43690, 16'd21845, 16'd32768, 1'b0, '0},
        '{16'd255,   16'd256,   16'd257,   1'b0, '0},
        '{16'd5,     16'd12,    16'd13,    1'b0, '0}
    };

    always #4 aclk = ~aclk;

    triangle_metrics_from_sides_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] isqrt128(input logic [127:0] v);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int k = 62; k >= 0; k--) begin
            t = r | (128'd1 << k);
            if (t * t <= v) begin
                r = t;
            end
        end
        return r[63:0];
    endfunction

    function automatic logic [27:0] atan_deg(input int idx);
        logic [27:0] tab [0:23];
        tab = '{28'd47185920, 28'd27855475, 28'd14718068, 28'd7471121, 28'd3750058,
                28'd1876857, 28'd938658, 28'd469357, 28'd234682, 28'd117342,
                28'd58671, 28'd29335, 28'd14668, 28'd7334, 28'd3667, 28'd1833,
                28'd917, 28'd458, 28'd229, 28'd115, 28'd57, 28'd29, 28'd14, 28'd7};
        return tab[idx];
    endfunction

    // Vectoring CORDIC on (|d| * 2^28, root); obtuse corners fold around 180.
    function automatic logic [tms_pkg::ANGLE_W-1:0] corner_angle(input logic [63:0] root,
                                                                 input longint d);
        bit             obtuse;
        logic [63:0]    ux;
        logic [63:0]    uy;
        logic [63:0]    mx;
        longint         x;
        longint         y;
        longint         z;
        longint         xs;
        longint         ys;
        logic [63:0]    zu;
        obtuse = d < 0;
        ux = (obtuse ? -d : d) << 28;
        uy = root;
        mx = (ux > uy) ? ux : uy;
        if (mx == 0) begin
            return '0;
        end
        while (mx >= (64'd1 << 41)) begin
            ux >>= 1; uy >>= 1; mx >>= 1;
        end
        while (mx < (64'd1 << 40)) begin
            ux <<= 1; uy <<= 1; mx <<= 1;
        end
        x = ux;
        y = uy;
        z = 0;
        for (int i = 0; i < 24; i++) begin
            xs = (x < 0) ? -((-x) >>> i) : (x >>> i);
            ys = (y < 0) ? -((-y) >>> i) : (y >>> i);
            if (y > 0) begin
                x = x + ys; y = y - xs; z += longint'(atan_deg(i));
            end else begin
                x = x - ys; y = y + xs; z -= longint'(atan_deg(i));
            end
        end
        if (z < 0) begin
            z = 0;
        end
        zu = z;
        if (zu > 64'(tms_pkg::DEG90)) begin
            zu = 64'(tms_pkg::DEG90);
        end
        if (obtuse) begin
            zu = 64'(tms_pkg::DEG180) - zu;
        end
        zu = (zu + 64'd2048) >> 12;
        if (zu > 64'(tms_pkg::ANGLE_MAX)) begin
            zu = 64'(tms_pkg::ANGLE_MAX);
        end
        return zu[tms_pkg::ANGLE_W-1:0];
    endfunction

    function automatic tms_pkg::out_t triangle_metrics(input tms_pkg::in_t req);
        tms_pkg::out_t res;
        longint       a;
        longint       b;
        longint       c;
        longint       aa;
        longint       bb;
        longint       cc;
        logic [127:0] heron;
        logic [63:0]  root;
        res = '0;
        a = longint'(req.side_a);
        b = longint'(req.side_b);
        c = longint'(req.side_c);
        if (a == 0 || b == 0 || c == 0) begin
            res.status = tms_pkg::STATUS_ZERO;
            return res;
        end
        if (a > b + c || b > a + c || c > a + b) begin
            res.status = tms_pkg::STATUS_INEQ;
            return res;
        end
        aa = a * a; bb = b * b; cc = c * c;
        heron = 128'(a + b + c) * 128'(b + c - a) * 128'(a + c - b) * 128'(a + b - c);
        root = isqrt128(heron << 56);
        res.status     = tms_pkg::STATUS_OK;
        res.perimeter  = tms_pkg::PERIM_W'(a + b + c);
        res.area       = tms_pkg::AREA_W'(root >> 38);
        res.angle_at_a = corner_angle(root, bb + cc - aa);
        res.angle_at_b = corner_angle(root, aa + cc - bb);
        res.angle_at_c = corner_angle(root, aa + bb - cc);
        res.is_right   = (aa == bb + cc || bb == aa + cc || cc == aa + bb);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic send_triangle(input tms_pkg::in_t req, input tms_pkg::out_t expected_res);
        int gap;
        if (!calm_phase && $urandom_range(0, 5) == 0) begin
            gap = int'($urandom_range(1, 18));
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= req;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(expected_res);
        @(negedge aclk);
    endtask

    function automatic tms_pkg::in_t random_triangle();
        tms_pkg::in_t req;
        int      mode;
        int      lo;
        int      hi;
        mode = int'($urandom_range(0, 19));
        if (mode < 14) begin
            // Well-formed triangle: c drawn between |a-b| and a+b; mode 13 then draws small sides at random.
            req.side_a = 16'($urandom_range(1, 65535));
            req.side_b = 16'($urandom_range(1, 65535));
            lo = (req.side_a > req.side_b) ? int'(req.side_a) - int'(req.side_b)
                                           : int'(req.side_b) - int'(req.side_a);
            hi = int'(req.side_a) + int'(req.side_b);
            if (lo < 1) begin
                lo = 1;
            end
            if (hi > 65535) begin
                hi = 65535;
            end
            req.side_c = 16'($urandom_range(lo, hi));
            if (mode == 13) begin
                req.side_a = 16'($urandom_range(1, 16));
                req.side_b = 16'($urandom_range(1, 16));
                req.side_c = 16'($urandom_range(1, 32));
            end
        end else if (mode < 16) begin
            // Right triangles scaled from 3-4-5.
            lo = int'($urandom_range(1, 13107));
            req.side_a = 16'(3 * lo);
            req.side_b = 16'(4 * lo);
            req.side_c = 16'(5 * lo);
        end else begin
            req = tms_pkg::in_t'(48'({$urandom, $urandom}));
            if (mode == 19) begin
                req.side_b = $urandom_range(0, 1) ? 16'd0 : req.side_b;
            end
        end
        return req;
    endfunction

    task automatic drain_all();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
    endtask

    initial begin
        tms_pkg::in_t req;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[i]) begin
            req = '{directed[i].a, directed[i].b, directed[i].c};
            send_triangle(req, directed[i].has_fixed ? directed[i].fixed
                                                     : triangle_metrics(req));
        end

        // Sender pauses until the pipeline has emptied.
        drain_all();

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 300) begin
                hold_request = 1'b1;
            end
            if (n == N_RANDOM - 150) begin
                calm_phase = 1'b1;
            end
            req = random_triangle();
            send_triangle(req, triangle_metrics(req));
        end
        s_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // ------------------------------------------------------------------
    // Receiver
    // ------------------------------------------------------------------
    initial begin
        int stall;
        int held;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                // Long hold-off so the pipeline fills and backs up the input.
                hold_request = 1'b0;
                m_ready <= 1'b0;
                held = 0;
                while (held < LONG_HOLD) begin
                    @(negedge aclk);
                    held++;
                end
                m_ready <= 1'b1;
            end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
                stall = int'($urandom_range(1, 18));
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        tms_pkg::out_t want;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request pending");
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("status",     32'(want.status),     32'(m_data.status));
                check_field("perimeter",  32'(want.perimeter),  32'(m_data.perimeter));
                check_field("area",       32'(want.area),       32'(m_data.area));
                check_field("angle_at_a", 32'(want.angle_at_a), 32'(m_data.angle_at_a));
                check_field("angle_at_b", 32'(want.angle_at_b), 32'(m_data.angle_at_b));
                check_field("angle_at_c", 32'(want.angle_at_c), 32'(m_data.angle_at_c));
                check_field("is_right",   32'(want.is_right),   32'(m_data.is_right));
            end
        end
    end

    // ------------------------------------------------------------------
    // End of run
    // ------------------------------------------------------------------
    initial begin
        wait (sending_done && expected_results.size() == 0);
        repeat (2 * LATENCY) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_CAP);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
